/* src/prr_pkg.sv */
// ----------------------------------------------------------------------------
// Plane point rotator package
// Shared constants for the rotator pipeline: the CORDIC gain, the width of
// the angle accumulator and the arctangent table in units of 2^-32 turn.
// ----------------------------------------------------------------------------
package prr_pkg;

	localparam int unsigned ATAN_COUNT = 24;
	localparam int unsigned Z_WIDTH    = 34;
	localparam int unsigned GAIN_WIDTH = 30;
	localparam int unsigned FRAC_SHIFT = 30;

	localparam logic [GAIN_WIDTH-1:0] GAIN_Q30 = 30'd652032874;

	function automatic logic [31:0] atan_turn(input int unsigned idx);
		logic [31:0] val;
		case (idx)
			0:       val = 32'd536870912;
			1:       val = 32'd316933405;
			2:       val = 32'd167458907;
			3:       val = 32'd85004756;
			4:       val = 32'd42667331;
			5:       val = 32'd21354465;
			6:       val = 32'd10679838;
			7:       val = 32'd5340245;
			8:       val = 32'd2670163;
			9:       val = 32'd1335086;
			10:      val = 32'd667544;
			11:      val = 32'd333772;
			12:      val = 32'd166886;
			13:      val = 32'd83443;
			14:      val = 32'd41721;
			15:      val = 32'd20860;
			16:      val = 32'd10430;
			17:      val = 32'd5215;
			18:      val = 32'd2607;
			19:      val = 32'd1303;
			20:      val = 32'd651;
			21:      val = 32'd325;
			22:      val = 32'd162;
			23:      val = 32'd81;
			default: val = 32'd0;
		endcase
		return val;
	endfunction

endpackage

/* src/plane_point_rotator_unit.sv */
// ----------------------------------------------------------------------------
// Plane point rotator
// Rotates one coordinate pair by a binary angle with a fully unrolled CORDIC
// pipeline: quarter-turn rotation, gain scaling, one micro-rotation per
// stage, then rounding and saturation.
//
//   Channel   Handshake      Fields
//   request   start / busy   coord_a, coord_b, turn_angle
//   result    done           rotated_a, rotated_b
//
// A request is taken in every cycle; busy stays low.
// At most 24 micro-rotation stages are built. The quarter-turn step, the
// gain multiplier, each micro-rotation and the rounding are each registered
// as a stage of their own. Reset clears only the valid bits.
// The receiver cannot stall, so done simply follows the pipeline.
// ----------------------------------------------------------------------------
module plane_point_rotator_unit
	import prr_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 24,
	parameter int unsigned ANGLE_WIDTH = 16,
	parameter int unsigned STAGES      = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] coord_a,
	input  logic signed [COORD_WIDTH-1:0] coord_b,
	input  logic        [ANGLE_WIDTH-1:0] turn_angle,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] rotated_a,
	output logic signed [COORD_WIDTH-1:0] rotated_b
);

	localparam int unsigned XW     = COORD_WIDTH + 33;
	localparam int unsigned NSTAGE = (STAGES < ATAN_COUNT) ? STAGES : ATAN_COUNT;

	logic                      chain_valid [0:NSTAGE];
	logic signed [XW-1:0]      chain_x     [0:NSTAGE];
	logic signed [XW-1:0]      chain_y     [0:NSTAGE];
	logic signed [Z_WIDTH-1:0] chain_z     [0:NSTAGE];

	assign busy = 1'b0;

	prr_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.ANGLE_WIDTH(ANGLE_WIDTH),
		.XW         (XW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.coord_a   (coord_a),
		.coord_b   (coord_b),
		.turn_angle(turn_angle),
		.valid_s2  (chain_valid[0]),
		.x_s2      (chain_x[0]),
		.y_s2      (chain_y[0]),
		.z_s2      (chain_z[0])
	);

	for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
		prr_micro_stage #(
			.XW (XW),
			.IDX(i)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (chain_valid[i]),
			.x_in     (chain_x[i]),
			.y_in     (chain_y[i]),
			.z_in     (chain_z[i]),
			.valid_out(chain_valid[i+1]),
			.x_out    (chain_x[i+1]),
			.y_out    (chain_y[i+1]),
			.z_out    (chain_z[i+1])
		);
	end

	prr_finish #(
		.COORD_WIDTH(COORD_WIDTH),
		.XW         (XW)
	) u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (chain_valid[NSTAGE]),
		.x_in     (chain_x[NSTAGE]),
		.y_in     (chain_y[NSTAGE]),
		.done     (done),
		.rotated_a(rotated_a),
		.rotated_b(rotated_b)
	);

endmodule

/* src/prr_front.sv */
// ----------------------------------------------------------------------------
// Plane point rotator front end
// Splits the angle into a quarter-turn count and a residual, rotates the
// pair by whole quarter turns, then scales both coordinates by the gain.
// ----------------------------------------------------------------------------
module prr_front
	import prr_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 24,
	parameter int unsigned ANGLE_WIDTH = 16,
	parameter int unsigned XW          = COORD_WIDTH + 33
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [COORD_WIDTH-1:0] coord_a,
	input  logic signed [COORD_WIDTH-1:0] coord_b,
	input  logic        [ANGLE_WIDTH-1:0] turn_angle,
	output logic                          valid_s2,
	output logic signed [XW-1:0]          x_s2,
	output logic signed [XW-1:0]          y_s2,
	output logic signed [Z_WIDTH-1:0]     z_s2
);

	localparam int unsigned EW = COORD_WIDTH + 1;
	localparam int unsigned PW = EW + GAIN_WIDTH + 1;
	localparam int unsigned RW = ANGLE_WIDTH - 1;

	logic [ANGLE_WIDTH:0]     biased;
	logic [1:0]               quad;
	logic signed [RW-1:0]     resid;
	logic signed [EW-1:0]     a_ext;
	logic signed [EW-1:0]     b_ext;
	logic signed [EW-1:0]     x_pre;
	logic signed [EW-1:0]     y_pre;
	logic signed [Z_WIDTH-1:0] z_pre;
	logic signed [PW-1:0]     x_prod;
	logic signed [PW-1:0]     y_prod;

	logic                     valid_s1;
	logic signed [EW-1:0]     x_s1;
	logic signed [EW-1:0]     y_s1;
	logic signed [Z_WIDTH-1:0] z_s1;

	always_comb begin
		biased = {1'b0, turn_angle} + ((ANGLE_WIDTH+1)'(1) << (ANGLE_WIDTH - 3));
		quad   = biased[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
		resid  = $signed({1'b0, biased[ANGLE_WIDTH-3:0]})
			- $signed(RW'(1) << (ANGLE_WIDTH - 3));
		a_ext  = {coord_a[COORD_WIDTH-1], coord_a};
		b_ext  = {coord_b[COORD_WIDTH-1], coord_b};
		case (quad)
			2'd1: begin
				x_pre = -b_ext;
				y_pre = a_ext;
			end
			2'd2: begin
				x_pre = -a_ext;
				y_pre = -b_ext;
			end
			2'd3: begin
				x_pre = b_ext;
				y_pre = -a_ext;
			end
			default: begin
				x_pre = a_ext;
				y_pre = b_ext;
			end
		endcase
		z_pre = $signed({{(Z_WIDTH-RW){resid[RW-1]}}, resid}) <<< (32 - ANGLE_WIDTH);
	end

	always_comb begin
		x_prod = PW'(x_s1) * $signed({1'b0, GAIN_Q30});
		y_prod = PW'(y_s1) * $signed({1'b0, GAIN_Q30});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= x_pre;
		y_s1 <= y_pre;
		z_s1 <= z_pre;
		x_s2 <= {{(XW-PW){x_prod[PW-1]}}, x_prod};
		y_s2 <= {{(XW-PW){y_prod[PW-1]}}, y_prod};
		z_s2 <= z_s1;
	end

endmodule

/* src/prr_micro_stage.sv */
// ----------------------------------------------------------------------------
// Plane point rotator micro-rotation stage
// One registered shift-add rotation step; the direction follows the sign of
// the remaining angle.
// ----------------------------------------------------------------------------
module prr_micro_stage
	import prr_pkg::*;
#(
	parameter int unsigned XW  = 57,
	parameter int unsigned IDX = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_in,
	input  logic signed [XW-1:0]      x_in,
	input  logic signed [XW-1:0]      y_in,
	input  logic signed [Z_WIDTH-1:0] z_in,
	output logic                      valid_out,
	output logic signed [XW-1:0]      x_out,
	output logic signed [XW-1:0]      y_out,
	output logic signed [Z_WIDTH-1:0] z_out
);

	localparam logic signed [Z_WIDTH-1:0] ATAN_STEP =
		$signed({{(Z_WIDTH-32){1'b0}}, atan_turn(IDX)});

	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;

	assign dx = y_in >>> IDX;
	assign dy = x_in >>> IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (!z_in[Z_WIDTH-1]) begin
			x_out <= x_in - dx;
			y_out <= y_in + dy;
			z_out <= z_in - ATAN_STEP;
		end else begin
			x_out <= x_in + dx;
			y_out <= y_in - dy;
			z_out <= z_in + ATAN_STEP;
		end
	end

endmodule

/* src/prr_finish.sv */
// ----------------------------------------------------------------------------
// Plane point rotator output stage
// Rounds both coordinates back to the input scale, dropping the 30 gain
// fraction bits, half up, and saturates them to the coordinate range.
// ----------------------------------------------------------------------------
module prr_finish
	import prr_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 24,
	parameter int unsigned XW          = COORD_WIDTH + 33
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_in,
	input  logic signed [XW-1:0]          x_in,
	input  logic signed [XW-1:0]          y_in,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] rotated_a,
	output logic signed [COORD_WIDTH-1:0] rotated_b
);

	localparam int unsigned RW = XW + 1 - FRAC_SHIFT;

	function automatic logic [COORD_WIDTH-1:0] round_sat(input logic [XW-1:0] v);
		logic [XW:0]   sum;
		logic [RW-1:0] r;
		logic          fits;
		logic [COORD_WIDTH-1:0] res;
		sum  = {v[XW-1], v} + ((XW+1)'(1) << (FRAC_SHIFT - 1));
		r    = sum[XW:FRAC_SHIFT];
		fits = (r[RW-1:COORD_WIDTH-1] == '0) || (r[RW-1:COORD_WIDTH-1] == '1);
		if (fits) begin
			res = r[COORD_WIDTH-1:0];
		end else if (r[RW-1]) begin
			res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
		end else begin
			res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
		end
		return res;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		rotated_a <= $signed(round_sat(x_in));
		rotated_b <= $signed(round_sat(y_in));
	end

endmodule
